// ===== rtl/qoisd_pkg.sv =====
// qoisd_pkg: shared types, codes and helpers for the qoi stream decoder
// used by qoisd_ctrl, qoisd_datapath and qoi_stream_decoder_top
`default_nettype none
package qoisd_pkg;

  localparam logic [31:0] MAX_SIDE = 32'd65535;
  localparam logic [31:0] QOI_MAGIC = 32'h716f6966;

  // result kinds
  localparam logic [2:0] KIND_HEADER   = 3'd0;
  localparam logic [2:0] KIND_PIXEL    = 3'd1;
  localparam logic [2:0] KIND_COMPLETE = 3'd2;
  localparam logic [2:0] KIND_PARTIAL  = 3'd3;
  localparam logic [2:0] KIND_ERROR    = 3'd4;

  // error codes
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_MAGIC      = 3'd1;
  localparam logic [2:0] ERR_TOO_LARGE  = 3'd2;
  localparam logic [2:0] ERR_ZERO_SIZE  = 3'd3;
  localparam logic [2:0] ERR_CHANNELS   = 3'd4;
  localparam logic [2:0] ERR_COLORSPACE = 3'd5;
  localparam logic [2:0] ERR_TRUNCATED  = 3'd6;

  // chunk opcodes and tag values
  localparam logic [7:0] OP_RGB    = 8'hfe;
  localparam logic [7:0] OP_RGBA   = 8'hff;
  localparam logic [1:0] TAG_INDEX = 2'b00;
  localparam logic [1:0] TAG_DIFF  = 2'b01;
  localparam logic [1:0] TAG_LUMA  = 2'b10;
  localparam logic [1:0] TAG_RUN   = 2'b11;

  // header byte positions with a check
  localparam logic [3:0] HPOS_MAGIC  = 4'd3;
  localparam logic [3:0] HPOS_WIDTH  = 4'd7;
  localparam logic [3:0] HPOS_HEIGHT = 4'd11;
  localparam logic [3:0] HPOS_CHAN   = 4'd12;
  localparam logic [3:0] HPOS_CSPACE = 4'd13;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_DECODE,
    PH_FULL,
    PH_ERROR,
    PH_DONE
  } phase_t;

  // what the current item needs after its first step
  typedef enum logic [1:0] {
    PLAN_NONE,
    PLAN_RES,
    PLAN_IDX,
    PLAN_PIX
  } plan_t;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [2:0]  channel_count;
    logic        color_space;
    logic [31:0] progress;
    logic [2:0]  error_code;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic take_rd;
    logic wr_hash;
    logic load_res;
    logic load_pix;
  } qoisd_cmd_t;

  typedef struct packed {
    plan_t plan;
    logic  out_free;
    logic  pix_last;
  } qoisd_stat_t;

  // index slot of a pixel packed as r g b a
  function automatic logic [5:0] qoisd_hash(input logic [31:0] p);
    logic [5:0] r;
    logic [5:0] g;
    logic [5:0] b;
    logic [5:0] a;
    r = p[29:24];
    g = p[21:16];
    b = p[13:8];
    a = p[5:0];
    return r * 6'd3 + g * 6'd5 + b * 6'd7 + a * 6'd11;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/qoisd_ctrl.sv =====
// qoisd_ctrl: sequencer for the qoi stream decoder
// depends on qoisd_pkg; drives commands into qoisd_datapath
`default_nettype none
module qoisd_ctrl import qoisd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire qoisd_stat_t stat,
  output qoisd_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_EMIT,
    S_READ,
    S_HASH,
    S_PIX
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != S_IDLE);

  // command decode and next state
  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        unique case (stat.plan)
          PLAN_NONE: state_next = S_IDLE;
          PLAN_RES:  state_next = S_EMIT;
          PLAN_IDX:  state_next = S_READ;
          PLAN_PIX:  state_next = S_HASH;
          default:   state_next = S_IDLE;
        endcase
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.load_res = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_READ: begin
        cmd.take_rd = 1'b1;
        state_next = S_HASH;
      end
      S_HASH: begin
        cmd.wr_hash = 1'b1;
        state_next = S_PIX;
      end
      S_PIX: begin
        if (stat.out_free) begin
          cmd.load_pix = 1'b1;
          if (stat.pix_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // pixel and status loads only happen with room in the output register
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_res || cmd.load_pix) |-> stat.out_free)
    else $error("output loaded while occupied");

  // an item is taken only while idle, and the next cycle runs its step
  a_capture_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> cmd.exec)
    else $error("captured item not executed");

  // an index chunk goes through a read before the hash write
  a_read_then_hash: assert property (@(posedge clk) disable iff (rst)
    cmd.take_rd |=> cmd.wr_hash)
    else $error("index read not followed by hash write");

endmodule
`default_nettype wire

// ===== rtl/qoisd_datapath.sv =====
// qoisd_datapath: header parser, chunk decoder, color index and output register
// depends on qoisd_pkg; controlled by qoisd_ctrl
`default_nettype none
module qoisd_datapath import qoisd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire in_item_t   in_item,
  input  wire logic       cfg_valid,
  input  wire logic       cfg_data,
  input  wire qoisd_cmd_t cmd,
  output qoisd_stat_t     stat,
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_item_t       out_item
);

  // item held for its step
  logic        act_q;
  logic [7:0]  byte_q;

  // decoder state
  logic        partial_en;
  phase_t      phase;
  logic [3:0]  hdr_pos;
  logic [31:0] hdr_word;
  logic [15:0] img_w;
  logic [15:0] img_h;
  logic [2:0]  chans;
  logic        cspace;
  logic [31:0] pixel;
  logic [31:0] pixels_done;
  logic [31:0] total;
  logic [7:0]  opcode;
  logic [2:0]  pending;
  logic [23:0] partial;
  logic [2:0]  err;
  logic [5:0]  run_cnt;
  out_item_t   res_hold;

  // color index memory with per-entry valid bits
  logic [31:0] idx_mem [64];
  logic [63:0] idx_vld;
  logic [31:0] rd_data;
  logic        rd_vld;

  // step results
  phase_t      phase_next;
  logic [3:0]  hdr_pos_next;
  logic [31:0] hdr_word_next;
  logic [15:0] img_w_next;
  logic [15:0] img_h_next;
  logic [2:0]  chans_next;
  logic        cspace_next;
  logic [31:0] pixel_next;
  logic [7:0]  opcode_next;
  logic [2:0]  pending_next;
  logic [23:0] partial_next;
  logic [2:0]  err_next;
  logic [5:0]  run_cnt_next;
  out_item_t   res_next;
  out_item_t   pix_res;
  plan_t       plan;

  logic [7:0]  pr;
  logic [7:0]  pg;
  logic [7:0]  pb;
  logic [7:0]  pa;
  logic [7:0]  dg;
  logic [7:0]  dr;
  logic [7:0]  db;
  logic [2:0]  pend_dec;
  logic [23:0] part_shift;
  logic        out_free;
  logic [31:0] done_inc;
  logic        pix_last;
  logic [5:0]  hash_slot;

  assign pr = pixel[31:24];
  assign pg = pixel[23:16];
  assign pb = pixel[15:8];
  assign pa = pixel[7:0];
  assign dg = {2'b00, opcode[5:0]} + 8'd224;
  assign dr = dg + {4'b0000, byte_q[7:4]} + 8'd248;
  assign db = dg + {4'b0000, byte_q[3:0]} + 8'd248;
  assign pend_dec = pending - 3'd1;
  assign part_shift = ((opcode == OP_RGBA) && (pending == 3'd1)) ? partial
                      : {partial[15:0], byte_q};

  assign out_free = !out_valid || !out_stall;
  assign done_inc = pixels_done + 32'd1;
  assign pix_last = (run_cnt == 6'd1) || (done_inc >= total);
  assign hash_slot = qoisd_hash(pixel);

  assign stat.plan = plan;
  assign stat.out_free = out_free;
  assign stat.pix_last = pix_last;

  // pixel item for the running pixel
  always_comb begin
    pix_res = '0;
    pix_res.kind = KIND_PIXEL;
    pix_res.red = pr;
    pix_res.green = pg;
    pix_res.blue = pb;
    pix_res.alpha = pa;
    pix_res.progress = pixels_done;
    pix_res.last = pix_last;
  end

  // one step of the decoder for the held item
  always_comb begin
    phase_next = phase;
    hdr_pos_next = hdr_pos;
    hdr_word_next = hdr_word;
    img_w_next = img_w;
    img_h_next = img_h;
    chans_next = chans;
    cspace_next = cspace;
    pixel_next = pixel;
    opcode_next = opcode;
    pending_next = pending;
    partial_next = partial;
    err_next = err;
    run_cnt_next = run_cnt;
    res_next = '0;
    res_next.progress = pixels_done;
    res_next.last = 1'b1;
    plan = PLAN_NONE;
    if (act_q) begin
      // end of stream
      phase_next = PH_DONE;
      plan = PLAN_RES;
      res_next.kind = KIND_ERROR;
      unique case (phase)
        PH_HEADER: res_next.error_code = ERR_TRUNCATED;
        PH_DECODE: begin
          if (pending == 3'd0 && partial_en) begin
            res_next.kind = KIND_PARTIAL;
          end else begin
            res_next.error_code = ERR_TRUNCATED;
          end
        end
        PH_FULL:  res_next.kind = KIND_COMPLETE;
        PH_ERROR: res_next.error_code = err;
        default: begin
          phase_next = phase;
          plan = PLAN_NONE;
        end
      endcase
    end else if (phase == PH_HEADER) begin
      hdr_word_next = {hdr_word[23:0], byte_q};
      hdr_pos_next = hdr_pos + 4'd1;
      res_next.kind = KIND_ERROR;
      case (hdr_pos)
        HPOS_MAGIC: begin
          if (hdr_word_next != QOI_MAGIC) begin
            res_next.error_code = ERR_MAGIC;
          end
        end
        HPOS_WIDTH: begin
          if (hdr_word_next > MAX_SIDE) begin
            res_next.error_code = ERR_TOO_LARGE;
          end else begin
            img_w_next = hdr_word_next[15:0];
          end
        end
        HPOS_HEIGHT: begin
          if (hdr_word_next > MAX_SIDE) begin
            res_next.error_code = ERR_TOO_LARGE;
          end else begin
            img_h_next = hdr_word_next[15:0];
            if (img_w == 16'd0 || hdr_word_next[15:0] == 16'd0) begin
              res_next.error_code = ERR_ZERO_SIZE;
            end
          end
        end
        HPOS_CHAN: begin
          if (byte_q != 8'd3 && byte_q != 8'd4) begin
            res_next.error_code = ERR_CHANNELS;
          end else begin
            chans_next = byte_q[2:0];
          end
        end
        HPOS_CSPACE: begin
          if (byte_q > 8'd1) begin
            res_next.error_code = ERR_COLORSPACE;
          end else begin
            cspace_next = byte_q[0];
            phase_next = PH_DECODE;
            plan = PLAN_RES;
            res_next.kind = KIND_HEADER;
            res_next.progress = '0;
            res_next.image_width = img_w;
            res_next.image_height = img_h;
            res_next.channel_count = chans;
            res_next.color_space = byte_q[0];
          end
        end
        default: ;
      endcase
      if (res_next.error_code != ERR_NONE) begin
        err_next = res_next.error_code;
        phase_next = PH_ERROR;
        plan = PLAN_RES;
      end
    end else if (phase == PH_DECODE) begin
      run_cnt_next = 6'd1;
      if (pending != 3'd0) begin
        // operand byte of a multi-byte chunk
        partial_next = part_shift;
        pending_next = pend_dec;
        if (pend_dec == 3'd0) begin
          plan = PLAN_PIX;
          if (opcode == OP_RGB) begin
            pixel_next = {part_shift, pa};
          end else if (opcode == OP_RGBA) begin
            pixel_next = {part_shift, byte_q};
          end else begin
            pixel_next = {pr + dr, pg + dg, pb + db, pa};
          end
        end
      end else begin
        // opcode byte
        opcode_next = byte_q;
        partial_next = '0;
        if (byte_q == OP_RGB) begin
          pending_next = 3'd3;
        end else if (byte_q == OP_RGBA) begin
          pending_next = 3'd4;
        end else begin
          unique case (byte_q[7:6])
            TAG_INDEX: plan = PLAN_IDX;
            TAG_DIFF: begin
              plan = PLAN_PIX;
              pixel_next = {pr + {6'd0, byte_q[5:4]} + 8'd254,
                            pg + {6'd0, byte_q[3:2]} + 8'd254,
                            pb + {6'd0, byte_q[1:0]} + 8'd254, pa};
            end
            TAG_LUMA: pending_next = 3'd1;
            TAG_RUN: begin
              plan = PLAN_PIX;
              run_cnt_next = byte_q[5:0] + 6'd1;
            end
            default: ;
          endcase
        end
      end
    end
  end

  // decoder state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      partial_en <= 1'b0;
      phase <= PH_HEADER;
      hdr_pos <= '0;
      hdr_word <= '0;
      img_w <= '0;
      img_h <= '0;
      chans <= '0;
      cspace <= 1'b0;
      pixel <= 32'h000000ff;
      pixels_done <= '0;
      total <= '0;
      opcode <= '0;
      pending <= '0;
      partial <= '0;
      err <= '0;
      run_cnt <= '0;
      idx_vld <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        partial_en <= cfg_data;
      end
      total <= 32'(img_w) * 32'(img_h);
      if (cmd.exec) begin
        phase <= phase_next;
        hdr_pos <= hdr_pos_next;
        hdr_word <= hdr_word_next;
        img_w <= img_w_next;
        img_h <= img_h_next;
        chans <= chans_next;
        cspace <= cspace_next;
        pixel <= pixel_next;
        opcode <= opcode_next;
        pending <= pending_next;
        partial <= partial_next;
        err <= err_next;
        run_cnt <= run_cnt_next;
      end
      if (cmd.take_rd) begin
        pixel <= rd_vld ? rd_data : 32'd0;
      end
      if (cmd.wr_hash) begin
        idx_vld[hash_slot] <= 1'b1;
      end
      if (cmd.load_pix) begin
        pixels_done <= done_inc;
        run_cnt <= run_cnt - 6'd1;
        if (done_inc >= total) begin
          phase <= PH_FULL;
        end
      end
      // output register
      if (cmd.load_res || cmd.load_pix) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // item capture, held result and output payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_q <= in_item.action;
      byte_q <= in_item.data_byte;
    end
    if (cmd.exec) begin
      res_hold <= res_next;
    end
    if (cmd.load_res) begin
      out_item <= res_hold;
    end else if (cmd.load_pix) begin
      out_item <= pix_res;
    end
  end

  // color index: read at the chunk's slot, write at the running pixel's hash
  always_ff @(posedge clk) begin
    rd_data <= idx_mem[byte_q[5:0]];
    rd_vld <= idx_vld[byte_q[5:0]];
    if (cmd.wr_hash) begin
      idx_mem[hash_slot] <= pixel;
    end
  end

  // while decoding the image is never already full
  a_not_full: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DECODE && !cmd.load_pix) |-> (pixels_done < total))
    else $error("decode phase with image full");

  // at most four operand bytes are ever outstanding
  a_pending: assert property (@(posedge clk) disable iff (rst)
    pending <= 3'd4)
    else $error("bad pending count");

  // pixel emission stops once the image is full
  a_stop_full: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_pix && done_inc >= total) |=> (phase == PH_FULL))
    else $error("phase not full after last pixel");

endmodule
`default_nettype wire

// ===== rtl/qoi_stream_decoder_top.sv =====
// qoi_stream_decoder_top: qoi image stream decoder, top level
// instantiates qoisd_ctrl and qoisd_datapath; types from qoisd_pkg
//
// usage:
//   in channel (in_valid/in_stall, in_item): one file byte per item, or an
//   end-of-stream item (action set). out channel (out_valid/out_stall,
//   out_item): header, pixel, complete, partial and error items, with last
//   set on the final item caused by an input item.
//   cfg channel (cfg_valid/cfg_ready, cfg_data): partial-finish enable;
//   always ready.
// steps:
//   an item is captured, then stepped; a header, status or error item adds
//   an output load; a diff, luma, rgb or rgba chunk adds an index write and
//   an output load; an index chunk adds a registered index read before those;
//   a run of n pixels adds the index write and an output load per pixel. one
//   output item at most per cycle, set by the single output register.
// reset: synchronous, clears the running pixel to opaque black, the color
//   index valid bits and the output valid flag.
// stall: an output item waits in the output register; input items that give
//   no item are still accepted, and the first that does waits until it drains.
`default_nettype none
module qoi_stream_decoder_top import qoisd_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_item,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_item_t     out_item,
  input  wire logic     cfg_valid,
  output logic          cfg_ready,
  input  wire logic     cfg_data
);

  qoisd_cmd_t  cmd;
  qoisd_stat_t stat;

  assign cfg_ready = 1'b1;

  qoisd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  qoisd_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

// ===== tb/qoisd_checker.sv =====
// qoisd_checker: watches the byte, result and config channels of the qoi decoder
// keeps its own decoder state and compares every result; types from qoisd_pkg
`timescale 1ns / 1ps
module qoisd_checker import qoisd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_item,
  input  logic      cfg_valid,
  input  logic      cfg_ready,
  input  logic      cfg_data,
  output int        fails,
  output int        pending
);

  // decoder state as seen from outside
  logic        partial_ok;
  phase_t      phase;
  logic [3:0]  hdr_pos;
  logic [31:0] hdr_word;
  logic [15:0] img_w;
  logic [15:0] img_h;
  logic [2:0]  img_ch;
  logic        img_cs;
  logic [31:0] cur_pix;
  logic [31:0] palette [64];
  logic [31:0] pix_count;
  logic [7:0]  chunk_op;
  logic [2:0]  bytes_left;
  logic [23:0] color_acc;
  logic [2:0]  err_code;

  out_item_t due_items [$];
  int        step_items;

  assign pending = due_items.size();

  function automatic logic [5:0] slot_of(input logic [31:0] p);
    logic [7:0] s;
    s = p[31:24] * 8'd3 + p[23:16] * 8'd5 + p[15:8] * 8'd7 + p[7:0] * 8'd11;
    return s[5:0];
  endfunction

  task automatic push_item(input out_item_t r);
    due_items.push_back(r);
    step_items++;
  endtask

  task automatic push_status(input logic [2:0] k, input logic [2:0] code);
    out_item_t r;
    r = '0;
    r.kind = k;
    r.progress = pix_count;
    r.error_code = code;
    push_item(r);
  endtask

  task automatic go_error(input logic [2:0] code);
    err_code = code;
    phase = PH_ERROR;
    push_status(KIND_ERROR, code);
  endtask

  // store the pixel in the index, then give up to n copies while the image has room
  task automatic give_pixels(input int n);
    out_item_t   r;
    logic [31:0] total;
    total = img_w * img_h;
    palette[slot_of(cur_pix)] = cur_pix;
    while (n > 0 && pix_count < total) begin
      r = '0;
      r.kind = KIND_PIXEL;
      {r.red, r.green, r.blue, r.alpha} = cur_pix;
      r.progress = pix_count;
      push_item(r);
      pix_count++;
      n--;
    end
    if (pix_count >= total) phase = PH_FULL;
  endtask

  task automatic header_byte(input logic [7:0] b);
    out_item_t  r;
    logic [3:0] pos;
    pos = hdr_pos;
    hdr_word = {hdr_word[23:0], b};
    hdr_pos = pos + 4'd1;
    case (pos)
      HPOS_MAGIC: begin
        if (hdr_word != QOI_MAGIC) go_error(ERR_MAGIC);
      end
      HPOS_WIDTH: begin
        if (hdr_word > MAX_SIDE) go_error(ERR_TOO_LARGE);
        else img_w = hdr_word[15:0];
      end
      HPOS_HEIGHT: begin
        if (hdr_word > MAX_SIDE) go_error(ERR_TOO_LARGE);
        else begin
          img_h = hdr_word[15:0];
          if (img_w == 0 || img_h == 0) go_error(ERR_ZERO_SIZE);
        end
      end
      HPOS_CHAN: begin
        if (b != 8'd3 && b != 8'd4) go_error(ERR_CHANNELS);
        else img_ch = b[2:0];
      end
      HPOS_CSPACE: begin
        if (b > 8'd1) go_error(ERR_COLORSPACE);
        else begin
          img_cs = b[0];
          phase = PH_DECODE;
          r = '0;
          r.kind = KIND_HEADER;
          r.image_width = img_w;
          r.image_height = img_h;
          r.channel_count = img_ch;
          r.color_space = img_cs;
          push_item(r);
        end
      end
      default: ;
    endcase
  endtask

  task automatic chunk_byte(input logic [7:0] b);
    logic [7:0] pr, pg, pb, pa, dg, dr, db;
    {pr, pg, pb, pa} = cur_pix;
    if (bytes_left != 0) begin
      if (!(chunk_op == OP_RGBA && bytes_left == 3'd1)) color_acc = {color_acc[15:0], b};
      bytes_left--;
      if (bytes_left == 0) begin
        if (chunk_op == OP_RGB) cur_pix = {color_acc, pa};
        else if (chunk_op == OP_RGBA) cur_pix = {color_acc, b};
        else begin
          // luma: green delta from the opcode, red and blue relative to it
          dg = {2'b00, chunk_op[5:0]} - 8'd32;
          dr = dg + {4'h0, b[7:4]} - 8'd8;
          db = dg + {4'h0, b[3:0]} - 8'd8;
          cur_pix = {pr + dr, pg + dg, pb + db, pa};
        end
        give_pixels(1);
      end
    end else begin
      chunk_op = b;
      color_acc = '0;
      if (b == OP_RGB) bytes_left = 3'd3;
      else if (b == OP_RGBA) bytes_left = 3'd4;
      else begin
        case (b[7:6])
          TAG_INDEX: begin
            cur_pix = palette[b[5:0]];
            give_pixels(1);
          end
          TAG_DIFF: begin
            cur_pix = {pr + {6'd0, b[5:4]} - 8'd2, pg + {6'd0, b[3:2]} - 8'd2,
                       pb + {6'd0, b[1:0]} - 8'd2, pa};
            give_pixels(1);
          end
          TAG_LUMA: bytes_left = 3'd1;
          default: give_pixels(int'(b[5:0]) + 1);
        endcase
      end
    end
  endtask

  task automatic stream_end();
    case (phase)
      PH_HEADER: go_error(ERR_TRUNCATED);
      PH_DECODE: begin
        if (bytes_left == 0 && partial_ok) push_status(KIND_PARTIAL, ERR_NONE);
        else go_error(ERR_TRUNCATED);
      end
      PH_FULL: push_status(KIND_COMPLETE, ERR_NONE);
      PH_ERROR: push_status(KIND_ERROR, err_code);
      default: ;
    endcase
    if (phase != PH_DONE) phase = PH_DONE;
  endtask

  task automatic decode_item(input in_item_t it);
    step_items = 0;
    if (it.action) stream_end();
    else if (phase == PH_HEADER) header_byte(it.data_byte);
    else if (phase == PH_DECODE) chunk_byte(it.data_byte);
    if (step_items > 0) due_items[due_items.size() - 1].last = 1'b1;
  endtask

  task automatic note_fail(input string what, input out_item_t exp_r, input out_item_t got);
    if (fails < 10) $display("%0t %s: expected %p got %p", $realtime, what, exp_r, got);
    fails++;
  endtask

  // compare results first: a result never stems from the byte taken at the same edge
  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst) begin
      partial_ok = 1'b0;
      phase = PH_HEADER;
      hdr_pos = '0;
      hdr_word = '0;
      img_w = '0;
      img_h = '0;
      img_ch = '0;
      img_cs = 1'b0;
      cur_pix = 32'h0000_00ff;
      for (int i = 0; i < 64; i++) palette[i] = '0;
      pix_count = '0;
      chunk_op = '0;
      bytes_left = '0;
      color_acc = '0;
      err_code = '0;
      fails = 0;
      due_items.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (due_items.size() == 0) note_fail("unexpected result", '0, out_item);
        else begin
          exp_r = due_items.pop_front();
          if (out_item.kind !== exp_r.kind || out_item.red !== exp_r.red ||
              out_item.green !== exp_r.green || out_item.blue !== exp_r.blue ||
              out_item.alpha !== exp_r.alpha || out_item.image_width !== exp_r.image_width ||
              out_item.image_height !== exp_r.image_height ||
              out_item.channel_count !== exp_r.channel_count ||
              out_item.color_space !== exp_r.color_space ||
              out_item.progress !== exp_r.progress ||
              out_item.error_code !== exp_r.error_code || out_item.last !== exp_r.last)
            note_fail("result mismatch", exp_r, out_item);
        end
      end
      if (cfg_valid && cfg_ready) partial_ok = cfg_data;
      if (in_valid && !in_stall) decode_item(in_item);
    end
  end

endmodule

// ===== tb/tb.sv =====
// tb: top of the qoi stream decoder testbench, makes the byte stream and gives the verdict
// depends on qoisd_pkg, qoi_stream_decoder_top and qoisd_checker
`timescale 1ns / 1ps
module tb import qoisd_pkg::*;;

  localparam int CYCLE_LIMIT = 1000000;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;
  logic      cfg_valid;
  logic      cfg_ready;
  logic      cfg_data;
  int        fails;
  int        pending;
  int        cycles;
  int        sent;
  bit        calm;

  qoi_stream_decoder_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  qoisd_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fails(fails), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // receiver stalls in bursts, and starts no new burst once calm
  initial begin
    int burst;
    out_stall = 1'b0;
    burst = 0;
    forever begin
      @(negedge clk);
      if (burst > 0) begin
        out_stall = 1'b1;
        burst--;
      end else if (!calm && $urandom_range(3) == 0) begin
        out_stall = 1'b1;
        burst = $urandom_range(9);
      end else out_stall = 1'b0;
    end
  end

  // one item, with a random idle burst before it; returns at the falling edge after acceptance
  task automatic put(input logic act, input logic [7:0] b);
    if (!calm && $urandom_range(4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(10, 1)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_item.action = act;
    in_item.data_byte = b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    sent++;
  endtask

  task automatic put_byte(input logic [7:0] b);
    put(1'b0, b);
  endtask

  // drain, let a trailing item still in the decoder finish, then write the register
  task automatic set_partial(input logic v);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic random_chunk();
    logic [7:0] op;
    case ($urandom_range(5))
      0: put_byte({TAG_INDEX, 6'($urandom)});
      1: put_byte({TAG_DIFF, 6'($urandom)});
      2: begin
        put_byte({TAG_LUMA, 6'($urandom)});
        put_byte(8'($urandom));
      end
      3: begin
        put_byte(OP_RGB);
        repeat (3) put_byte(8'($urandom));
      end
      4: begin
        put_byte(OP_RGBA);
        repeat (4) put_byte(8'($urandom));
      end
      default: begin
        op = {TAG_RUN, 6'($urandom_range(61))};
        put_byte(op);
      end
    endcase
  endtask

  initial begin
    logic [15:0] w, h;
    calm = 1'b0;
    cycles = 0;
    sent = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    repeat (9) @(negedge clk);
    rst = 1'b0;
    set_partial(1'b1);

    // image size: small so it fills up, medium, or the widest line
    case ($urandom_range(2))
      0: begin
        w = 16'($urandom_range(12, 1));
        h = 16'($urandom_range(12, 1));
      end
      1: begin
        w = 16'($urandom_range(300, 100));
        h = 16'($urandom_range(200, 50));
      end
      default: begin
        w = 16'hffff;
        h = 16'($urandom_range(3, 1));
      end
    endcase

    // header
    put_byte(8'h71); put_byte(8'h6f); put_byte(8'h69); put_byte(8'h66);
    put_byte(8'h00); put_byte(8'h00); put_byte(w[15:8]); put_byte(w[7:0]);
    put_byte(8'h00); put_byte(8'h00); put_byte(h[15:8]); put_byte(h[7:0]);
    put_byte($urandom_range(1) ? 8'd4 : 8'd3);
    put_byte(8'($urandom_range(1)));

    // every chunk kind at its extremes
    put_byte(OP_RGBA); put_byte(8'hff); put_byte(8'h00); put_byte(8'hff); put_byte(8'h00);
    put_byte(OP_RGB); put_byte(8'h00); put_byte(8'hff); put_byte(8'h00);
    put_byte(8'h40); put_byte(8'h7f);
    put_byte(8'h80); put_byte(8'h00); put_byte(8'hbf); put_byte(8'hff);
    put_byte(8'h00); put_byte(8'h3f);
    put_byte(8'hc0); put_byte(8'hfd);

    set_partial(1'b0);
    while (sent < 140) random_chunk();
    set_partial(1'($urandom_range(1)));
    calm = 1'b0;
    while (sent < 245) begin
      if (sent > 200) calm = 1'b1;
      random_chunk();
    end

    // end of stream, sometimes inside a chunk
    if ($urandom_range(3) == 0) begin
      put_byte(OP_RGB);
      put_byte(8'($urandom));
    end
    put(1'b1, 8'($urandom));
    in_valid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (fails == 0 && pending == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/qoisd_pkg.sv
rtl/qoisd_ctrl.sv
rtl/qoisd_datapath.sv
rtl/qoi_stream_decoder_top.sv
tb/qoisd_checker.sv
tb/tb.sv
